>>> hdl/eip_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eip_pkg
// Shared types and constants of the Ethernet / IPv4 header parser.
// ----------------------------------------------------------------------------
package eip_pkg;

  localparam int VALUE_W     = 48;
  localparam int KIND_W      = 5;
  localparam int POS_W       = 7;
  localparam int SHIFT_W     = 40;  // longest partial field kept between bytes
  localparam int OWL_W       = 4;
  localparam int MAX_RESULTS = 4;
  localparam int CNT_W       = 3;

  typedef logic [KIND_W-1:0]  kind_t;
  typedef logic [VALUE_W-1:0] value_t;
  typedef logic [POS_W-1:0]   pos_t;

  localparam kind_t KIND_DMAC    = 5'd0;
  localparam kind_t KIND_SMAC    = 5'd1;
  localparam kind_t KIND_TYPE    = 5'd2;
  localparam kind_t KIND_VER     = 5'd3;
  localparam kind_t KIND_IHL     = 5'd4;
  localparam kind_t KIND_DSCP    = 5'd5;
  localparam kind_t KIND_ECN     = 5'd6;
  localparam kind_t KIND_TOTLEN  = 5'd7;
  localparam kind_t KIND_ID      = 5'd8;
  localparam kind_t KIND_FLAGS   = 5'd9;
  localparam kind_t KIND_FRAGOFF = 5'd10;
  localparam kind_t KIND_TTL     = 5'd11;
  localparam kind_t KIND_PROTO   = 5'd12;
  localparam kind_t KIND_CSUM    = 5'd13;
  localparam kind_t KIND_SIP     = 5'd14;
  localparam kind_t KIND_DIP     = 5'd15;
  localparam kind_t KIND_OPTION  = 5'd16;
  localparam kind_t KIND_PAYLOAD = 5'd17;
  localparam kind_t KIND_IHL_ERR = 5'd18;
  localparam kind_t KIND_TRUNC   = 5'd19;

  // byte positions at which a header field completes; POS_OPT is the first option byte
  localparam pos_t POS_DMAC    = 7'd5;
  localparam pos_t POS_SMAC    = 7'd11;
  localparam pos_t POS_TYPE    = 7'd13;
  localparam pos_t POS_VER_IHL = 7'd14;
  localparam pos_t POS_TOS     = 7'd15;
  localparam pos_t POS_TOTLEN  = 7'd17;
  localparam pos_t POS_ID      = 7'd19;
  localparam pos_t POS_FRAG    = 7'd21;
  localparam pos_t POS_TTL     = 7'd22;
  localparam pos_t POS_PROTO   = 7'd23;
  localparam pos_t POS_CSUM    = 7'd25;
  localparam pos_t POS_SIP     = 7'd29;
  localparam pos_t POS_DIP     = 7'd33;
  localparam pos_t POS_OPT     = 7'd34;

  localparam logic [3:0] IHL_MIN = 4'd5;

  typedef struct packed {
    kind_t  kind;
    value_t value;
  } res_t;

  // all results caused by one input item, in order
  typedef struct packed {
    logic [CNT_W-1:0]       count;
    logic                   eof;
    res_t [MAX_RESULTS-1:0] item;
  } bundle_t;

endpackage

>>> hdl/eip_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eip_decode
// Frame position tracking and per-byte field decode into a result bundle.
// ----------------------------------------------------------------------------
module eip_decode import eip_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] data_byte,
  input  logic       frame_end,
  output bundle_t    bundle
);

  pos_t               pos_r, pos_nxt;
  logic [SHIFT_W-1:0] shift_r, shift_nxt;
  logic [OWL_W-1:0]   owl_r, owl_nxt;
  logic               pay_r, pay_nxt;

  function automatic bundle_t push(bundle_t b, kind_t k, value_t v);
    bundle_t r;
    r = b;
    r.item[b.count[1:0]].kind  = k;
    r.item[b.count[1:0]].value = v;
    r.count = b.count + 3'd1;
    return r;
  endfunction

  always_comb begin
    value_t           acc;
    logic             done;
    logic [OWL_W-1:0] owl_dec;
    acc       = {shift_r, data_byte};
    done      = 1'b1;
    owl_dec   = '0;
    bundle    = '0;
    pos_nxt   = pos_r;
    shift_nxt = shift_r;
    owl_nxt   = owl_r;
    pay_nxt   = pay_r;
    if (pay_r) begin
      bundle = push(bundle, KIND_PAYLOAD, VALUE_W'(data_byte));
    end else begin
      pos_nxt = pos_r + 7'd1;
      unique case (pos_r)
        POS_DMAC:  bundle = push(bundle, KIND_DMAC, acc);
        POS_SMAC:  bundle = push(bundle, KIND_SMAC, acc);
        POS_TYPE:  bundle = push(bundle, KIND_TYPE, acc);
        POS_VER_IHL: begin
          bundle = push(bundle, KIND_VER, VALUE_W'(data_byte[7:4]));
          bundle = push(bundle, KIND_IHL, VALUE_W'(data_byte[3:0]));
          if (data_byte[3:0] < IHL_MIN) begin
            bundle  = push(bundle, KIND_IHL_ERR, '0);
            owl_nxt = '0;
          end else begin
            owl_nxt = data_byte[3:0] - IHL_MIN;
          end
        end
        POS_TOS: begin
          bundle = push(bundle, KIND_DSCP, VALUE_W'(data_byte[7:2]));
          bundle = push(bundle, KIND_ECN, VALUE_W'(data_byte[1:0]));
        end
        POS_TOTLEN: bundle = push(bundle, KIND_TOTLEN, acc);
        POS_ID:     bundle = push(bundle, KIND_ID, acc);
        POS_FRAG: begin
          bundle = push(bundle, KIND_FLAGS, VALUE_W'(acc[15:13]));
          bundle = push(bundle, KIND_FRAGOFF, VALUE_W'(acc[12:0]));
        end
        POS_TTL:   bundle = push(bundle, KIND_TTL, acc);
        POS_PROTO: bundle = push(bundle, KIND_PROTO, acc);
        POS_CSUM:  bundle = push(bundle, KIND_CSUM, acc);
        POS_SIP:   bundle = push(bundle, KIND_SIP, acc);
        POS_DIP: begin
          bundle = push(bundle, KIND_DIP, acc);
          if (owl_r == '0) begin
            pay_nxt = 1'b1;
          end
        end
        default: begin
          // option words end where (pos - 34) mod 4 is 3
          if (pos_r >= POS_OPT && pos_r[1:0] == 2'd1) begin
            bundle  = push(bundle, KIND_OPTION, acc);
            owl_dec = (owl_r != '0) ? owl_r - 4'd1 : '0;
            owl_nxt = owl_dec;
            if (owl_dec == '0) begin
              pay_nxt = 1'b1;
            end
          end else begin
            done = 1'b0;
          end
        end
      endcase
      shift_nxt = done ? '0 : acc[SHIFT_W-1:0];
    end
    if (frame_end) begin
      if (!pay_nxt) begin
        bundle = push(bundle, KIND_TRUNC, '0);
      end
      bundle.eof = 1'b1;
      pos_nxt    = '0;
      shift_nxt  = '0;
      owl_nxt    = '0;
      pay_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      shift_r <= '0;
      owl_r   <= '0;
      pay_r   <= 1'b0;
    end else if (accept) begin
      pos_r   <= pos_nxt;
      shift_r <= shift_nxt;
      owl_r   <= owl_nxt;
      pay_r   <= pay_nxt;
    end
  end

`ifndef SYNTHESIS
  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    accept && frame_end |=> pos_r == '0 && shift_r == '0 && owl_r == '0 && !pay_r)
    else $error("state not cleared after final byte");

  a_payload_no_opts: assert property (@(posedge clk) disable iff (!rst_n)
    pay_r |-> owl_r == '0)
    else $error("payload reached with option words pending");

  a_final_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    frame_end |-> bundle.count != '0)
    else $error("final byte yields no result");
`endif

endmodule

>>> hdl/eip_serializer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eip_serializer
// Result register: holds one item's results and hands them out one per cycle while out_stall is low.
// ----------------------------------------------------------------------------
module eip_serializer import eip_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  bundle_t bundle,
  output logic    load_ok,
  output logic    out_valid,
  input  logic    out_stall,
  output kind_t   out_field_kind,
  output value_t  out_field_value,
  output logic    out_end_of_frame
);

  logic [CNT_W-1:0]       count_r, count_nxt;
  logic                   eof_r, eof_nxt;
  res_t [MAX_RESULTS-1:0] item_r, item_nxt;
  logic                   take;

  assign out_valid        = count_r != '0;
  assign take             = out_valid && !out_stall;
  assign load_ok          = (count_r == '0) || (count_r == 3'd1 && !out_stall);
  assign out_field_kind   = item_r[0].kind;
  assign out_field_value  = item_r[0].value;
  assign out_end_of_frame = eof_r && count_r == 3'd1;

  always_comb begin
    count_nxt = count_r;
    eof_nxt   = eof_r;
    item_nxt  = item_r;
    if (load) begin
      count_nxt = bundle.count;
      eof_nxt   = bundle.eof;
      item_nxt  = bundle.item;
    end else if (take) begin
      count_nxt = count_r - 3'd1;
      for (int i = 0; i < MAX_RESULTS - 1; i++) begin
        item_nxt[i] = item_r[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      eof_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      eof_r   <= eof_nxt;
    end
    item_r <= item_nxt;
  end

`ifndef SYNTHESIS
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(count_r) && $stable(item_r) && $stable(eof_r))
    else $error("pending results changed while stalled");

  a_drain_step: assert property (@(posedge clk) disable iff (!rst_n)
    take && count_r > 3'd1 |=> count_r == $past(count_r) - 3'd1)
    else $error("result count did not step down");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 3'd4)
    else $error("more pending results than slots");
`endif

endmodule

>>> hdl/eth_ipv4_header_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eth_ipv4_header_parser
// Byte-wide Ethernet + IPv4 header parser emitting tagged header fields,
// option words, payload bytes and error markers.
// ----------------------------------------------------------------------------
// a byte's first result is on the output in the cycle after the byte is accepted
// one byte per cycle while each byte gives at most one result and out_stall is low
// a byte giving several results (up to 4 when a frame with a short header
// length ends on its version/ihl byte) holds the output register until all are
// taken; in_stall is high while more than one is pending or the last is stalled
// synchronous active-low reset returns to start of frame, no results pending
module eth_ipv4_header_parser import eip_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_frame_end,
  output logic       out_valid,
  input  logic       out_stall,
  output kind_t      out_field_kind,
  output value_t     out_field_value,
  output logic       out_end_of_frame
);

  bundle_t bundle;
  logic    load_ok;
  logic    accept;

  assign in_stall = !load_ok;
  assign accept   = in_valid && load_ok;

  eip_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .data_byte (in_data_byte),
    .frame_end (in_frame_end),
    .bundle    (bundle)
  );

  eip_serializer u_serializer (
    .clk              (clk),
    .rst_n            (rst_n),
    .load             (accept),
    .bundle           (bundle),
    .load_ok          (load_ok),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_field_kind   (out_field_kind),
    .out_field_value  (out_field_value),
    .out_end_of_frame (out_end_of_frame)
  );

endmodule
